// File: sv/bgbd_pkg.sv
// Shared constants and types of the GBRG bilinear demosaic block.
`timescale 1ns / 1ps

package bgbd_pkg;

  // Frame geometry
  localparam int          MAX_SIDE_DEF = 1024;
  localparam int          SIDE_W       = 11;
  localparam logic [10:0] SIDE_RESET   = 11'd64;

  // Sample and colour width
  localparam int PIX_W = 8;

  // Configuration port
  localparam int         APB_DW         = 32;
  localparam int         APB_AW         = 2;
  localparam logic [1:0] REG_IMAGE_SIDE = 2'd0;

  // Output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  // Where the window centre of one request lies in the frame
  typedef struct packed {
    logic produce;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic row_odd;
    logic col_odd;
    logic frame_end;
  } site_t;

  // One finished RGB pixel
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } pix_t;

endpackage

// File: sv/bgbd_in_if.sv
// Raw sample channel: valid/ready handshake with Bayer sample and pad flag.
`timescale 1ns / 1ps

interface bgbd_in_if;
  logic                       valid;
  logic                       ready;
  logic [bgbd_pkg::PIX_W-1:0] raw_sample;
  logic                       pad;

  modport source (output valid, output raw_sample, output pad, input ready);
  modport sink   (input valid, input raw_sample, input pad, output ready);
endinterface

// File: sv/bgbd_out_if.sv
// RGB pixel channel: valid/ready handshake with colour values and frame end.
`timescale 1ns / 1ps

interface bgbd_out_if;
  logic                       valid;
  logic                       ready;
  logic [bgbd_pkg::PIX_W-1:0] red;
  logic [bgbd_pkg::PIX_W-1:0] green;
  logic [bgbd_pkg::PIX_W-1:0] blue;
  logic                       frame_end;

  modport source (output valid, output red, output green, output blue,
                  output frame_end, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input frame_end, output ready);
endinterface

// File: sv/bgbd_cfg.sv
// APB register file holding the frame side length, with clamped working copy.
`timescale 1ns / 1ps

module bgbd_cfg #(
  parameter int  MAX_SIDE = bgbd_pkg::MAX_SIDE_DEF,
  localparam int SW       = $clog2(MAX_SIDE + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgbd_pkg::APB_AW-1:0]   paddr,
  input  logic [bgbd_pkg::APB_DW-1:0]   pwdata,
  output logic [bgbd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic                          restart,
  output logic [SW-1:0]                 side
);

  localparam int EW = (SW > bgbd_pkg::SIDE_W) ? SW : bgbd_pkg::SIDE_W;

  logic [bgbd_pkg::SIDE_W-1:0] image_side_r;
  logic [SW-1:0]               side_r;
  logic                        wr_en;

  // Limit a written side length to the range the line stores support
  function automatic logic [SW-1:0] clamp_side(input logic [bgbd_pkg::SIDE_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (ve < EW'(2)) begin
      return SW'(2);
    end else if (ve > EW'(MAX_SIDE)) begin
      return SW'(MAX_SIDE);
    end else begin
      return SW'(ve);
    end
  endfunction

  assign wr_en  = psel && penable && pwrite && (paddr == bgbd_pkg::REG_IMAGE_SIDE);
  assign pready = 1'b1;

  // Read back the register as written
  always_comb begin
    if (paddr == bgbd_pkg::REG_IMAGE_SIDE) begin
      prdata = bgbd_pkg::APB_DW'(image_side_r);
    end else begin
      prdata = '0;
    end
  end

  // Hold the register and its clamped copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_side_r <= bgbd_pkg::SIDE_RESET;
      side_r       <= clamp_side(bgbd_pkg::SIDE_RESET);
    end else if (wr_en) begin
      image_side_r <= pwdata[bgbd_pkg::SIDE_W-1:0];
      side_r       <= clamp_side(pwdata[bgbd_pkg::SIDE_W-1:0]);
    end
  end

  assign restart = wr_en;
  assign side    = side_r;

endmodule

// File: sv/bgbd_scan.sv
// Raster position counters: line store address and window centre site flags.
`timescale 1ns / 1ps

module bgbd_scan #(
  parameter int  MAX_SIDE = bgbd_pkg::MAX_SIDE_DEF,
  localparam int SW       = $clog2(MAX_SIDE + 1),
  localparam int CW       = $clog2(MAX_SIDE),
  localparam int RW       = $clog2(MAX_SIDE + 2)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        restart,
  input  logic [SW-1:0]               side,
  input  logic                        accept,
  input  logic                        pad,
  input  logic [bgbd_pkg::PIX_W-1:0]  raw_sample,
  output logic [CW-1:0]               rd_col,
  output logic [bgbd_pkg::PIX_W-1:0]  sample,
  output bgbd_pkg::site_t             site
);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_w;
  logic [SW-1:0] side_m1;
  logic          col_zero;
  logic [CW-1:0] cx, cy;
  logic [RW-1:0] row_m1, row_m2;
  logic [SW:0]   col_inc;
  logic [RW:0]   row_inc;

  assign side_m1  = side - SW'(1);
  assign col_w    = (SW'(col_r) >= side) ? '0 : col_r;
  assign col_zero = (col_w == '0);
  assign row_m1   = row_r - RW'(1);
  assign row_m2   = row_r - RW'(2);

  // Locate the window centre: one pixel behind and one row above the sample
  always_comb begin
    if (col_zero) begin
      cx = CW'(side_m1);
      cy = CW'(row_m2);
    end else begin
      cx = col_w - CW'(1);
      cy = CW'(row_m1);
    end
  end

  // Classify the centre site
  always_comb begin
    site.produce   = (row_r >= RW'(2)) || ((row_r == RW'(1)) && !col_zero);
    site.top       = (cy == '0);
    site.bottom    = (SW'(cy) == side_m1);
    site.left      = (cx == '0);
    site.right     = (SW'(cx) == side_m1);
    site.row_odd   = cy[0];
    site.col_odd   = cx[0];
    site.frame_end = site.bottom && site.right;
  end

  assign rd_col = col_w;
  assign sample = pad ? '0 : raw_sample;

  // Advance the raster position; drop back to the origin after the last pixel
  always_comb begin
    col_inc = (SW + 1)'(col_w) + (SW + 1)'(1);
    row_inc = (RW + 1)'(row_r) + (RW + 1)'(1);
    col_nxt = col_w;
    row_nxt = row_r;
    if (site.produce && site.frame_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_inc >= (SW + 1)'(side)) begin
      col_nxt = '0;
      if (row_inc > (RW + 1)'(side) + (RW + 1)'(1)) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_inc[RW-1:0];
      end
    end else begin
      col_nxt = col_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: sv/bgbd_window.sv
// Line store memory, 3x3 window and bilinear colour interpolation.
`timescale 1ns / 1ps

module bgbd_window #(
  parameter int  MAX_SIDE = bgbd_pkg::MAX_SIDE_DEF,
  localparam int CW       = $clog2(MAX_SIDE)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [CW-1:0]               rd_col,
  input  logic [bgbd_pkg::PIX_W-1:0]  sample,
  input  bgbd_pkg::site_t             site,
  output logic                        busy,
  output logic                        push,
  output bgbd_pkg::pix_t              pix
);

  localparam int PW = bgbd_pkg::PIX_W;

  // Both line stores share one word: older row in the upper half
  logic [2*PW-1:0] line_mem [MAX_SIDE];
  logic [2*PW-1:0] mem_q_r;
  logic [2*PW-1:0] line_q;
  logic [2*PW-1:0] wr_data;

  logic                s1_valid_r;
  logic [CW-1:0]       s1_col_r;
  logic [PW-1:0]       s1_sample_r;
  bgbd_pkg::site_t     s1_site_r;
  logic                fwd_hit_r;
  logic [2*PW-1:0]     fwd_data_r;

  logic [PW-1:0] win_r   [3][3];
  logic [PW-1:0] win_nxt [3][3];
  logic [PW-1:0] nb      [3][3];
  logic [PW:0]   sum_v, sum_h;
  logic [PW+1:0] cross_sum, diag;

  // Take the column just written when the same entry is read back to back
  assign line_q  = fwd_hit_r ? fwd_data_r : mem_q_r;
  assign wr_data = {line_q[PW-1:0], s1_sample_r};

  // Read on request, write back the shifted column in the next cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q_r <= line_mem[rd_col];
    end
    if (s1_valid_r) begin
      line_mem[s1_col_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        fwd_hit_r <= s1_valid_r && (s1_col_r == rd_col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r    <= rd_col;
      s1_sample_r <= sample;
      s1_site_r   <= site;
      fwd_data_r  <= wr_data;
    end
  end

  // Shift the window left and bring in the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = line_q[2*PW-1:PW];
    win_nxt[1][2] = line_q[PW-1:0];
    win_nxt[2][2] = s1_sample_r;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  // Zero neighbours that fall outside the frame
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && s1_site_r.top) || (r == 2 && s1_site_r.bottom) ||
            (c == 0 && s1_site_r.left) || (c == 2 && s1_site_r.right)) begin
          nb[r][c] = '0;
        end else begin
          nb[r][c] = win_nxt[r][c];
        end
      end
    end
  end

  assign sum_v     = (PW + 1)'(nb[0][1]) + (PW + 1)'(nb[2][1]);
  assign sum_h     = (PW + 1)'(nb[1][0]) + (PW + 1)'(nb[1][2]);
  assign cross_sum = (PW + 2)'(sum_v) + (PW + 2)'(sum_h);
  assign diag      = (PW + 2)'(nb[0][0]) + (PW + 2)'(nb[0][2]) +
                     (PW + 2)'(nb[2][0]) + (PW + 2)'(nb[2][2]);

  // Pick each colour by site parity
  always_comb begin
    pix.frame_end = s1_site_r.frame_end;
    unique case ({s1_site_r.row_odd, s1_site_r.col_odd})
      2'b00: begin
        pix.green = nb[1][1];
        pix.red   = sum_v[PW:1];
        pix.blue  = sum_h[PW:1];
      end
      2'b11: begin
        pix.green = nb[1][1];
        pix.red   = sum_h[PW:1];
        pix.blue  = sum_v[PW:1];
      end
      2'b10: begin
        pix.red   = nb[1][1];
        pix.green = cross_sum[PW+1:2];
        pix.blue  = diag[PW+1:2];
      end
      default: begin
        pix.blue  = nb[1][1];
        pix.green = cross_sum[PW+1:2];
        pix.red   = diag[PW+1:2];
      end
    endcase
  end

  assign push = s1_valid_r && s1_site_r.produce;
  assign busy = s1_valid_r;

endmodule

// File: sv/bgbd_ofifo.sv
// Small output queue that decouples the pixel pipeline from receiver stalls.
`timescale 1ns / 1ps

module bgbd_ofifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  bgbd_pkg::pix_t               push_data,
  input  logic                         pop,
  output logic                         not_empty,
  output bgbd_pkg::pix_t               head,
  output logic [bgbd_pkg::OQ_CW-1:0]   level
);

  bgbd_pkg::pix_t                 q_mem [bgbd_pkg::OQ_DEPTH];
  logic [bgbd_pkg::OQ_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [bgbd_pkg::OQ_CW-1:0]     count_r;
  logic                           do_pop;

  assign do_pop    = pop && (count_r != '0);
  assign not_empty = (count_r != '0);
  assign head      = q_mem[rd_ptr_r];
  assign level     = count_r;

  // Store pushed pixels
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + bgbd_pkg::OQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + bgbd_pkg::OQ_AW'(1);
      end
      unique case ({push, do_pop})
        2'b10:   count_r <= count_r + bgbd_pkg::OQ_CW'(1);
        2'b01:   count_r <= count_r - bgbd_pkg::OQ_CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: sv/bayer_gbrg_bilinear_demosaic.sv
// Bilinear demosaic of a square GBRG Bayer frame, one sample a cycle when ready.
//
// Usage:
//   Send raw 8-bit samples on in_chan in raster order, side*side of them, then
//   side+1 requests with pad set to flush the last pixels. Each request from
//   row 1, column 1 onwards yields one RGB pixel on out_chan, the pixel one row
//   and one column behind the sample; frame_end marks the last pixel, after
//   which the next request starts a new frame.
//   The side length is APB register 0, bits 10:0; a write also restarts the
//   frame. Write it only while the block is idle; the block does not enforce it.
// Timing:
//   One request per cycle while in_chan.ready is high. The pixel completed by
//   a request is offered on out_chan once the synchronous read of the
//   dual-port line store word has registered and the window update and
//   colour sums have registered into a four-entry output queue.
//   in_chan.ready falls when queued pixels plus the one in flight exceed two,
//   so a stalled receiver holds results without loss.
// Reset:
//   Side returns to 64 and the position to the frame origin. The line stores
//   are not cleared; stale entries only ever fall outside the frame.
`timescale 1ns / 1ps

module bayer_gbrg_bilinear_demosaic #(
  parameter int MAX_SIDE = bgbd_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bgbd_in_if.sink                       in_chan,
  bgbd_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgbd_pkg::APB_AW-1:0]   paddr,
  input  logic [bgbd_pkg::APB_DW-1:0]   pwdata,
  output logic [bgbd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = $clog2(MAX_SIDE);

  logic                          restart;
  logic [SW-1:0]                 side;
  logic                          accept;
  logic [CW-1:0]                 rd_col;
  logic [bgbd_pkg::PIX_W-1:0]    sample;
  bgbd_pkg::site_t               site;
  logic                          busy;
  logic                          push;
  bgbd_pkg::pix_t                pix;
  bgbd_pkg::pix_t                head;
  logic                          not_empty;
  logic [bgbd_pkg::OQ_CW-1:0]    level;

  // Take a request only when the queue has room for it and the one in flight
  assign in_chan.ready = ((bgbd_pkg::OQ_CW + 1)'(level) + (bgbd_pkg::OQ_CW + 1)'(busy))
                         <= (bgbd_pkg::OQ_CW + 1)'(bgbd_pkg::OQ_DEPTH - 2);
  assign accept = in_chan.valid && in_chan.ready;

  bgbd_cfg #(.MAX_SIDE(MAX_SIDE)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .restart (restart),
    .side    (side)
  );

  bgbd_scan #(.MAX_SIDE(MAX_SIDE)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .side       (side),
    .accept     (accept),
    .pad        (in_chan.pad),
    .raw_sample (in_chan.raw_sample),
    .rd_col     (rd_col),
    .sample     (sample),
    .site       (site)
  );

  bgbd_window #(.MAX_SIDE(MAX_SIDE)) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .rd_col (rd_col),
    .sample (sample),
    .site   (site),
    .busy   (busy),
    .push   (push),
    .pix    (pix)
  );

  bgbd_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (pix),
    .pop       (out_chan.ready),
    .not_empty (not_empty),
    .head      (head),
    .level     (level)
  );

  // Present the queue head
  assign out_chan.valid     = not_empty;
  assign out_chan.red       = head.red;
  assign out_chan.green     = head.green;
  assign out_chan.blue      = head.blue;
  assign out_chan.frame_end = head.frame_end;

endmodule
